FILE: sv/lorenz_pkg.sv
`timescale 1ns / 1ps

package lorenz_pkg;

  // signed word format, Q15.16
  localparam int WORD_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int DT_W      = 31;
  localparam int PROD_W    = 2 * WORD_W;
  // magnitude of a full product plus rounding constant
  localparam int MAG_W     = PROD_W - 1;
  // divide-by-three digit loop
  localparam int DIV_STEPS = 8;
  localparam int Q_W       = ((MAG_W - FRAC_W + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
  localparam int DIV_CYC   = Q_W / DIV_STEPS;
  localparam int DCNT_W    = $clog2(DIV_CYC);

  localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGMA  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RHO    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_END    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_METHOD = 3'd5;

  localparam logic [WORD_W-1:0] SIGMA_RST = 32'd655360;
  localparam logic [WORD_W-1:0] RHO_RST   = 32'd1835008;
  localparam logic [WORD_W-1:0] BETA_RST  = 32'd174763;
  localparam logic [DT_W-1:0]   DT_RST    = 31'd655;
  localparam logic [WORD_W-1:0] END_RST   = 32'd6553600;

  localparam logic ITEM_LOAD     = 1'b0;
  localparam logic ITEM_STEP     = 1'b1;
  localparam logic METHOD_EULER  = 1'b0;
  localparam logic METHOD_RK4    = 1'b1;

  // operand / destination codes: below 16 is scratch memory, 16 and up is state, config or zero
  localparam int OPR_W = 5;
  localparam logic [OPR_W-1:0] OPR_W0   = 5'd0;
  localparam logic [OPR_W-1:0] OPR_W1   = 5'd1;
  localparam logic [OPR_W-1:0] OPR_W2   = 5'd2;
  localparam logic [OPR_W-1:0] OPR_K0   = 5'd3;
  localparam logic [OPR_W-1:0] OPR_K1   = 5'd4;
  localparam logic [OPR_W-1:0] OPR_K2   = 5'd5;
  localparam logic [OPR_W-1:0] OPR_S0   = 5'd6;
  localparam logic [OPR_W-1:0] OPR_S1   = 5'd7;
  localparam logic [OPR_W-1:0] OPR_S2   = 5'd8;
  localparam logic [OPR_W-1:0] OPR_U    = 5'd9;
  localparam logic [OPR_W-1:0] OPR_V    = 5'd10;
  localparam logic [OPR_W-1:0] OPR_X    = 5'd16;
  localparam logic [OPR_W-1:0] OPR_Y    = 5'd17;
  localparam logic [OPR_W-1:0] OPR_Z    = 5'd18;
  localparam logic [OPR_W-1:0] OPR_T    = 5'd19;
  localparam logic [OPR_W-1:0] OPR_SIG  = 5'd20;
  localparam logic [OPR_W-1:0] OPR_RHO  = 5'd21;
  localparam logic [OPR_W-1:0] OPR_BET  = 5'd22;
  localparam logic [OPR_W-1:0] OPR_DT   = 5'd23;
  localparam logic [OPR_W-1:0] OPR_ZERO = 5'd24;

  localparam int SCR_DEPTH = 16;
  localparam int SCR_AW    = $clog2(SCR_DEPTH);

  localparam int PC_W      = 7;
  localparam int UCODE_LEN = 82;
  localparam logic [PC_W-1:0] PC_EULER = 7'd75;

  typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL} op_e;
  typedef enum logic [1:0] {DIV_1, DIV_2, DIV_6} div_e;
  typedef enum logic [1:0] {BR_NEXT, BR_EULER, BR_END} br_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FETCH, ST_EXEC, ST_ROUND, ST_SCALE, ST_DIV, ST_SAT, ST_EMIT
  } state_e;

  typedef struct packed {
    op_e              op;
    logic [OPR_W-1:0] src_a;
    logic [OPR_W-1:0] src_b;
    logic [OPR_W-1:0] dst;
    div_e             div;
    br_e              br;
    logic [PC_W-1:0]  tgt;
  } ctrl_t;

  function automatic ctrl_t cw(input op_e op, input logic [OPR_W-1:0] a,
                               input logic [OPR_W-1:0] b, input logic [OPR_W-1:0] d,
                               input div_e dv, input br_e br);
    ctrl_t w;
    w.op    = op;
    w.src_a = a;
    w.src_b = b;
    w.dst   = d;
    w.div   = dv;
    w.br    = br;
    w.tgt   = '0;
    return w;
  endfunction

  // microprogram: rk4 body first, euler tail at PC_EULER
  function automatic ctrl_t ucode_word(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = cw(OP_ADD, OPR_ZERO, OPR_ZERO, OPR_U, DIV_1, BR_END);
    case (pc)
      // k1 = f(x, y, z)
      7'd0:  w = cw(OP_SUB, OPR_Y,    OPR_X,    OPR_U,  DIV_1, BR_NEXT);
      7'd1:  w = cw(OP_MUL, OPR_SIG,  OPR_U,    OPR_K0, DIV_1, BR_NEXT);
      7'd2:  w = cw(OP_SUB, OPR_RHO,  OPR_Z,    OPR_U,  DIV_1, BR_NEXT);
      7'd3:  w = cw(OP_MUL, OPR_X,    OPR_U,    OPR_U,  DIV_1, BR_NEXT);
      7'd4:  w = cw(OP_SUB, OPR_U,    OPR_Y,    OPR_K1, DIV_1, BR_NEXT);
      7'd5:  w = cw(OP_MUL, OPR_X,    OPR_Y,    OPR_U,  DIV_1, BR_NEXT);
      7'd6:  w = cw(OP_MUL, OPR_BET,  OPR_Z,    OPR_V,  DIV_1, BR_NEXT);
      7'd7:  begin
        w = cw(OP_SUB, OPR_U, OPR_V, OPR_K2, DIV_1, BR_EULER);
        w.tgt = PC_EULER;
      end
      7'd8:  w = cw(OP_ADD, OPR_K0,   OPR_ZERO, OPR_S0, DIV_1, BR_NEXT);
      7'd9:  w = cw(OP_ADD, OPR_K1,   OPR_ZERO, OPR_S1, DIV_1, BR_NEXT);
      7'd10: w = cw(OP_ADD, OPR_K2,   OPR_ZERO, OPR_S2, DIV_1, BR_NEXT);
      // w = v + dt*k1/2
      7'd11: w = cw(OP_MUL, OPR_DT,   OPR_K0,   OPR_U,  DIV_2, BR_NEXT);
      7'd12: w = cw(OP_ADD, OPR_X,    OPR_U,    OPR_W0, DIV_1, BR_NEXT);
      7'd13: w = cw(OP_MUL, OPR_DT,   OPR_K1,   OPR_U,  DIV_2, BR_NEXT);
      7'd14: w = cw(OP_ADD, OPR_Y,    OPR_U,    OPR_W1, DIV_1, BR_NEXT);
      7'd15: w = cw(OP_MUL, OPR_DT,   OPR_K2,   OPR_U,  DIV_2, BR_NEXT);
      7'd16: w = cw(OP_ADD, OPR_Z,    OPR_U,    OPR_W2, DIV_1, BR_NEXT);
      // k2 = f(w)
      7'd17: w = cw(OP_SUB, OPR_W1,   OPR_W0,   OPR_U,  DIV_1, BR_NEXT);
      7'd18: w = cw(OP_MUL, OPR_SIG,  OPR_U,    OPR_K0, DIV_1, BR_NEXT);
      7'd19: w = cw(OP_SUB, OPR_RHO,  OPR_W2,   OPR_U,  DIV_1, BR_NEXT);
      7'd20: w = cw(OP_MUL, OPR_W0,   OPR_U,    OPR_U,  DIV_1, BR_NEXT);
      7'd21: w = cw(OP_SUB, OPR_U,    OPR_W1,   OPR_K1, DIV_1, BR_NEXT);
      7'd22: w = cw(OP_MUL, OPR_W0,   OPR_W1,   OPR_U,  DIV_1, BR_NEXT);
      7'd23: w = cw(OP_MUL, OPR_BET,  OPR_W2,   OPR_V,  DIV_1, BR_NEXT);
      7'd24: w = cw(OP_SUB, OPR_U,    OPR_V,    OPR_K2, DIV_1, BR_NEXT);
      // s += 2*k2
      7'd25: w = cw(OP_ADD, OPR_K0,   OPR_K0,   OPR_U,  DIV_1, BR_NEXT);
      7'd26: w = cw(OP_ADD, OPR_S0,   OPR_U,    OPR_S0, DIV_1, BR_NEXT);
      7'd27: w = cw(OP_ADD, OPR_K1,   OPR_K1,   OPR_U,  DIV_1, BR_NEXT);
      7'd28: w = cw(OP_ADD, OPR_S1,   OPR_U,    OPR_S1, DIV_1, BR_NEXT);
      7'd29: w = cw(OP_ADD, OPR_K2,   OPR_K2,   OPR_U,  DIV_1, BR_NEXT);
      7'd30: w = cw(OP_ADD, OPR_S2,   OPR_U,    OPR_S2, DIV_1, BR_NEXT);
      // w = v + dt*k2/2
      7'd31: w = cw(OP_MUL, OPR_DT,   OPR_K0,   OPR_U,  DIV_2, BR_NEXT);
      7'd32: w = cw(OP_ADD, OPR_X,    OPR_U,    OPR_W0, DIV_1, BR_NEXT);
      7'd33: w = cw(OP_MUL, OPR_DT,   OPR_K1,   OPR_U,  DIV_2, BR_NEXT);
      7'd34: w = cw(OP_ADD, OPR_Y,    OPR_U,    OPR_W1, DIV_1, BR_NEXT);
      7'd35: w = cw(OP_MUL, OPR_DT,   OPR_K2,   OPR_U,  DIV_2, BR_NEXT);
      7'd36: w = cw(OP_ADD, OPR_Z,    OPR_U,    OPR_W2, DIV_1, BR_NEXT);
      // k3 = f(w)
      7'd37: w = cw(OP_SUB, OPR_W1,   OPR_W0,   OPR_U,  DIV_1, BR_NEXT);
      7'd38: w = cw(OP_MUL, OPR_SIG,  OPR_U,    OPR_K0, DIV_1, BR_NEXT);
      7'd39: w = cw(OP_SUB, OPR_RHO,  OPR_W2,   OPR_U,  DIV_1, BR_NEXT);
      7'd40: w = cw(OP_MUL, OPR_W0,   OPR_U,    OPR_U,  DIV_1, BR_NEXT);
      7'd41: w = cw(OP_SUB, OPR_U,    OPR_W1,   OPR_K1, DIV_1, BR_NEXT);
      7'd42: w = cw(OP_MUL, OPR_W0,   OPR_W1,   OPR_U,  DIV_1, BR_NEXT);
      7'd43: w = cw(OP_MUL, OPR_BET,  OPR_W2,   OPR_V,  DIV_1, BR_NEXT);
      7'd44: w = cw(OP_SUB, OPR_U,    OPR_V,    OPR_K2, DIV_1, BR_NEXT);
      // s += 2*k3
      7'd45: w = cw(OP_ADD, OPR_K0,   OPR_K0,   OPR_U,  DIV_1, BR_NEXT);
      7'd46: w = cw(OP_ADD, OPR_S0,   OPR_U,    OPR_S0, DIV_1, BR_NEXT);
      7'd47: w = cw(OP_ADD, OPR_K1,   OPR_K1,   OPR_U,  DIV_1, BR_NEXT);
      7'd48: w = cw(OP_ADD, OPR_S1,   OPR_U,    OPR_S1, DIV_1, BR_NEXT);
      7'd49: w = cw(OP_ADD, OPR_K2,   OPR_K2,   OPR_U,  DIV_1, BR_NEXT);
      7'd50: w = cw(OP_ADD, OPR_S2,   OPR_U,    OPR_S2, DIV_1, BR_NEXT);
      // w = v + dt*k3
      7'd51: w = cw(OP_MUL, OPR_DT,   OPR_K0,   OPR_U,  DIV_1, BR_NEXT);
      7'd52: w = cw(OP_ADD, OPR_X,    OPR_U,    OPR_W0, DIV_1, BR_NEXT);
      7'd53: w = cw(OP_MUL, OPR_DT,   OPR_K1,   OPR_U,  DIV_1, BR_NEXT);
      7'd54: w = cw(OP_ADD, OPR_Y,    OPR_U,    OPR_W1, DIV_1, BR_NEXT);
      7'd55: w = cw(OP_MUL, OPR_DT,   OPR_K2,   OPR_U,  DIV_1, BR_NEXT);
      7'd56: w = cw(OP_ADD, OPR_Z,    OPR_U,    OPR_W2, DIV_1, BR_NEXT);
      // k4 = f(w)
      7'd57: w = cw(OP_SUB, OPR_W1,   OPR_W0,   OPR_U,  DIV_1, BR_NEXT);
      7'd58: w = cw(OP_MUL, OPR_SIG,  OPR_U,    OPR_K0, DIV_1, BR_NEXT);
      7'd59: w = cw(OP_SUB, OPR_RHO,  OPR_W2,   OPR_U,  DIV_1, BR_NEXT);
      7'd60: w = cw(OP_MUL, OPR_W0,   OPR_U,    OPR_U,  DIV_1, BR_NEXT);
      7'd61: w = cw(OP_SUB, OPR_U,    OPR_W1,   OPR_K1, DIV_1, BR_NEXT);
      7'd62: w = cw(OP_MUL, OPR_W0,   OPR_W1,   OPR_U,  DIV_1, BR_NEXT);
      7'd63: w = cw(OP_MUL, OPR_BET,  OPR_W2,   OPR_V,  DIV_1, BR_NEXT);
      7'd64: w = cw(OP_SUB, OPR_U,    OPR_V,    OPR_K2, DIV_1, BR_NEXT);
      // s += k4, v += dt*s/6
      7'd65: w = cw(OP_ADD, OPR_S0,   OPR_K0,   OPR_S0, DIV_1, BR_NEXT);
      7'd66: w = cw(OP_ADD, OPR_S1,   OPR_K1,   OPR_S1, DIV_1, BR_NEXT);
      7'd67: w = cw(OP_ADD, OPR_S2,   OPR_K2,   OPR_S2, DIV_1, BR_NEXT);
      7'd68: w = cw(OP_MUL, OPR_DT,   OPR_S0,   OPR_U,  DIV_6, BR_NEXT);
      7'd69: w = cw(OP_ADD, OPR_X,    OPR_U,    OPR_X,  DIV_1, BR_NEXT);
      7'd70: w = cw(OP_MUL, OPR_DT,   OPR_S1,   OPR_U,  DIV_6, BR_NEXT);
      7'd71: w = cw(OP_ADD, OPR_Y,    OPR_U,    OPR_Y,  DIV_1, BR_NEXT);
      7'd72: w = cw(OP_MUL, OPR_DT,   OPR_S2,   OPR_U,  DIV_6, BR_NEXT);
      7'd73: w = cw(OP_ADD, OPR_Z,    OPR_U,    OPR_Z,  DIV_1, BR_NEXT);
      7'd74: w = cw(OP_ADD, OPR_T,    OPR_DT,   OPR_T,  DIV_1, BR_END);
      // euler: v += dt*k1
      7'd75: w = cw(OP_MUL, OPR_DT,   OPR_K0,   OPR_U,  DIV_1, BR_NEXT);
      7'd76: w = cw(OP_ADD, OPR_X,    OPR_U,    OPR_X,  DIV_1, BR_NEXT);
      7'd77: w = cw(OP_MUL, OPR_DT,   OPR_K1,   OPR_U,  DIV_1, BR_NEXT);
      7'd78: w = cw(OP_ADD, OPR_Y,    OPR_U,    OPR_Y,  DIV_1, BR_NEXT);
      7'd79: w = cw(OP_MUL, OPR_DT,   OPR_K2,   OPR_U,  DIV_1, BR_NEXT);
      7'd80: w = cw(OP_ADD, OPR_Z,    OPR_U,    OPR_Z,  DIV_1, BR_NEXT);
      7'd81: w = cw(OP_ADD, OPR_T,    OPR_DT,   OPR_T,  DIV_1, BR_END);
      default: ;
    endcase
    return w;
  endfunction

endpackage

FILE: sv/lorenz_attractor_integrator.sv
`timescale 1ns / 1ps

// Lorenz system integrator in signed Q15.16 with saturating arithmetic. A load transaction
// (tuser = 0) sets x, y, z and time and returns nothing. A step transaction (tuser = 1)
// advances the state by one forward Euler or classical RK4 step and then returns time, x,
// y, z as they were before the step; once time has reached end_time the step returns the
// unchanged state with the done flag and no advance. The advance runs a microprogram on one
// shared 32x32 multiplier: an add or subtract instruction goes through fetch and execute, a
// multiply through fetch, multiply, round, scale and saturate, and a multiply by dt/6 also
// through the 8-bit-per-cycle divide by three. Input is taken again once the step's result
// is in the output register; the result sits there until the downstream side takes it.
// Configuration writes are expected only while no step is in flight.

module lorenz_attractor_integrator import lorenz_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // x_in[31:0], y_in[63:32], z_in[95:64], time_in[127:96]
  input  logic [4*WORD_W-1:0]   s_axis_tdata,
  // op[0]
  input  logic [0:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // time_out[31:0], x_out[63:32], y_out[95:64], z_out[127:96]
  output logic [4*WORD_W-1:0]   m_axis_tdata,
  // done_flag[0], saturated_flag[1]
  output logic [1:0]            m_axis_tuser,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [WORD_W-1:0]     cfg_data_i
);

  localparam logic [MAG_W-1:0] RND_1 = MAG_W'(1) << (FRAC_W - 1);
  localparam logic [MAG_W-1:0] RND_2 = MAG_W'(1) << FRAC_W;
  localparam logic [MAG_W-1:0] RND_6 = MAG_W'(3) << FRAC_W;
  localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(DIV_CYC - 1);

  // configuration
  logic [WORD_W-1:0] sigma_q, rho_q, beta_q, end_q;
  logic [DT_W-1:0]   dt_q;
  logic              method_q;

  // state and sequencer
  state_e                   state_q, state_d;
  logic [PC_W-1:0]          pc_q, pc_d;
  ctrl_t                    ctrl;
  logic signed [WORD_W-1:0] x_q, y_q, z_q, t_q;
  logic [WORD_W-1:0]        scr_mem [SCR_DEPTH];

  // datapath
  logic signed [WORD_W-1:0] opa_q, opb_q;
  logic signed [PROD_W-1:0] prod_q;
  logic                     neg_q;
  logic [MAG_W-1:0]         mag_q;
  logic [Q_W-1:0]           quo_q, quo_n;
  logic [1:0]               rem_q, rem_n;
  logic [DCNT_W-1:0]        dcnt_q;
  logic [2:0]               div_part;
  logic                     div_bit;

  logic [WORD_W:0]          sum_w;
  logic [WORD_W-1:0]        add_res, mul_res, wr_val, mul_lim;
  logic                     add_sat, mul_sat, wr_sat;
  logic [MAG_W-1:0]         rnd_sel;

  logic                     wr_en, retire, emit_load;
  logic                     in_take, load_take, step_take, at_end;

  // sample and result registers
  logic [4*WORD_W-1:0]      snap_q, out_data_q;
  logic [1:0]               out_user_q;
  logic                     out_valid_q, done_q, sat_q;

  assign ctrl          = ucode_word(pc_q);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign load_take     = in_take && (s_axis_tuser[0] == ITEM_LOAD);
  assign step_take     = in_take && (s_axis_tuser[0] == ITEM_STEP);
  assign at_end        = !(t_q < $signed(end_q));

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sigma_q  <= SIGMA_RST;
      rho_q    <= RHO_RST;
      beta_q   <= BETA_RST;
      dt_q     <= DT_RST;
      end_q    <= END_RST;
      method_q <= METHOD_RK4;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SIGMA:  sigma_q  <= cfg_data_i;
        CFG_RHO:    rho_q    <= cfg_data_i;
        CFG_BETA:   beta_q   <= cfg_data_i;
        CFG_DT:     dt_q     <= cfg_data_i[DT_W-1:0];
        CFG_END:    end_q    <= cfg_data_i;
        CFG_METHOD: method_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  function automatic logic [WORD_W-1:0] fixed_src(input logic [OPR_W-1:0] code);
    logic [WORD_W-1:0] v;
    case (code)
      OPR_X:   v = x_q;
      OPR_Y:   v = y_q;
      OPR_Z:   v = z_q;
      OPR_T:   v = t_q;
      OPR_SIG: v = sigma_q;
      OPR_RHO: v = rho_q;
      OPR_BET: v = beta_q;
      OPR_DT:  v = {1'b0, dt_q};
      default: v = '0;
    endcase
    return v;
  endfunction

  // saturating add / subtract
  always_comb begin
    if (ctrl.op == OP_SUB) begin
      sum_w = {opa_q[WORD_W-1], opa_q} - {opb_q[WORD_W-1], opb_q};
    end else begin
      sum_w = {opa_q[WORD_W-1], opa_q} + {opb_q[WORD_W-1], opb_q};
    end
    add_sat = sum_w[WORD_W] ^ sum_w[WORD_W-1];
    if (add_sat) begin
      add_res = sum_w[WORD_W] ? WORD_MIN : WORD_MAX;
    end else begin
      add_res = sum_w[WORD_W-1:0];
    end
  end

  always_comb begin
    case (ctrl.div)
      DIV_2:   rnd_sel = RND_2;
      DIV_6:   rnd_sel = RND_6;
      default: rnd_sel = RND_1;
    endcase
  end

  // divide by three, one quotient bit per inner step
  always_comb begin
    quo_n    = quo_q;
    rem_n    = rem_q;
    div_part = '0;
    div_bit  = 1'b0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      div_part = {rem_n, quo_n[Q_W-1]};
      div_bit  = (div_part >= 3'd3);
      rem_n    = div_bit ? 2'(div_part - 3'd3) : div_part[1:0];
      quo_n    = {quo_n[Q_W-2:0], div_bit};
    end
  end

  // saturate the scaled magnitude and restore the sign
  always_comb begin
    mul_lim = neg_q ? WORD_MIN : WORD_MAX;
    mul_sat = quo_q > Q_W'(mul_lim);
    if (mul_sat) begin
      mul_res = neg_q ? WORD_MIN : WORD_MAX;
    end else if (neg_q) begin
      mul_res = -quo_q[WORD_W-1:0];
    end else begin
      mul_res = quo_q[WORD_W-1:0];
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    pc_d      = pc_q;
    retire    = 1'b0;
    wr_en     = 1'b0;
    wr_val    = add_res;
    wr_sat    = add_sat;
    emit_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (step_take) begin
          pc_d    = '0;
          state_d = at_end ? ST_EMIT : ST_FETCH;
        end
      end
      ST_FETCH: state_d = ST_EXEC;
      ST_EXEC: begin
        if (ctrl.op == OP_MUL) begin
          state_d = ST_ROUND;
        end else begin
          wr_en  = 1'b1;
          retire = 1'b1;
        end
      end
      ST_ROUND: state_d = ST_SCALE;
      ST_SCALE: state_d = (ctrl.div == DIV_6) ? ST_DIV : ST_SAT;
      ST_DIV: begin
        if (dcnt_q == DCNT_LAST) begin
          state_d = ST_SAT;
        end
      end
      ST_SAT: begin
        wr_en  = 1'b1;
        wr_val = mul_res;
        wr_sat = mul_sat;
        retire = 1'b1;
      end
      ST_EMIT: begin
        if (!out_valid_q || m_axis_tready) begin
          emit_load = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (retire) begin
      if (ctrl.br == BR_END) begin
        state_d = ST_EMIT;
      end else begin
        state_d = ST_FETCH;
        if (ctrl.br == BR_EULER && method_q == METHOD_EULER) begin
          pc_d = ctrl.tgt;
        end else begin
          pc_d = pc_q + 1'b1;
        end
      end
    end
  end

  // integrator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= '0;
      z_q <= '0;
      t_q <= '0;
    end else if (load_take) begin
      x_q <= s_axis_tdata[WORD_W-1:0];
      y_q <= s_axis_tdata[2*WORD_W-1:WORD_W];
      z_q <= s_axis_tdata[3*WORD_W-1:2*WORD_W];
      t_q <= s_axis_tdata[4*WORD_W-1:3*WORD_W];
    end else if (wr_en) begin
      case (ctrl.dst)
        OPR_X:   x_q <= wr_val;
        OPR_Y:   y_q <= wr_val;
        OPR_Z:   z_q <= wr_val;
        OPR_T:   t_q <= wr_val;
        default: ;
      endcase
    end
  end

  // scratch memory and operand fetch
  always_ff @(posedge clk_i) begin
    if (wr_en && !ctrl.dst[OPR_W-1]) begin
      scr_mem[ctrl.dst[SCR_AW-1:0]] <= wr_val;
    end
    if (state_q == ST_FETCH) begin
      opa_q <= ctrl.src_a[OPR_W-1] ? fixed_src(ctrl.src_a) : scr_mem[ctrl.src_a[SCR_AW-1:0]];
      opb_q <= ctrl.src_b[OPR_W-1] ? fixed_src(ctrl.src_b) : scr_mem[ctrl.src_b[SCR_AW-1:0]];
    end
  end

  // multiply, round to nearest with ties away from zero, scale
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_EXEC:  prod_q <= PROD_W'(opa_q) * PROD_W'(opb_q);
      ST_ROUND: begin
        neg_q <= prod_q[PROD_W-1];
        // magnitude and rounding share one adder: ~p + rnd + 1
        if (prod_q[PROD_W-1]) begin
          mag_q <= ~prod_q[MAG_W-1:0] + rnd_sel + MAG_W'(1);
        end else begin
          mag_q <= prod_q[MAG_W-1:0] + rnd_sel;
        end
      end
      ST_SCALE: begin
        rem_q <= '0;
        if (ctrl.div == DIV_1) begin
          quo_q <= Q_W'(mag_q >> FRAC_W);
        end else begin
          quo_q <= Q_W'(mag_q >> (FRAC_W + 1));
        end
      end
      ST_DIV: begin
        quo_q <= quo_n;
        rem_q <= rem_n;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (state_q == ST_DIV) begin
      dcnt_q <= dcnt_q + 1'b1;
    end else begin
      dcnt_q <= '0;
    end
  end

  // step flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      sat_q  <= 1'b0;
    end else if (step_take) begin
      done_q <= at_end;
      sat_q  <= 1'b0;
    end else if (wr_en && wr_sat) begin
      sat_q  <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_take) begin
      snap_q <= {z_q, y_q, x_q, t_q};
    end
    if (emit_load) begin
      out_data_q <= snap_q;
      out_user_q <= {sat_q, done_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_load |=> m_axis_tvalid)
    else $error("result register not loaded after emit");

  a_pc_in_rom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE && state_q != ST_EMIT) |-> pc_q < PC_W'(UCODE_LEN))
    else $error("microprogram counter left the program");

  a_div_sixth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> ctrl.div == DIV_6)
    else $error("divide by three entered for a non-sixth multiply");

  a_done_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> !m_axis_tuser[1])
    else $error("done result reports saturation");

endmodule
